// ----- design/hangul_grid_stack_machine_defines.svh -----
// Assertion macros for the grid stack machine.
`ifndef HANGUL_GRID_STACK_MACHINE_DEFINES_SVH
`define HANGUL_GRID_STACK_MACHINE_DEFINES_SVH

`ifndef SYNTHESIS
`define HGSM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define HGSM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define HGSM_ASSERT(name, prop, msg)
`define HGSM_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- design/hgsm_pkg.sv -----
package hgsm_pkg;

  localparam int GRID_COLS_DEF   = 128;
  localparam int GRID_ROWS_DEF   = 128;
  localparam int STORE_DEPTH_DEF = 128;
  localparam int NUM_STORES      = 28;

  localparam logic [4:0]  QUEUE_STORE  = 5'd21;
  localparam logic [20:0] HANGUL_FIRST = 21'h00AC00;
  localparam logic [20:0] HANGUL_LAST  = 21'h00D7A3;
  localparam logic [13:0] NOP_CELL     = 14'd6496;
  localparam logic [4:0]  FIN_IN_NUM   = 5'd21;
  localparam logic [4:0]  FIN_IN_CHR   = 5'd27;

  localparam logic [14:0] DEC_M1     = 15'd28533;
  localparam logic [9:0]  INIT_SPAN  = 10'd588;
  localparam logic [9:0]  DEC_M2     = 10'd586;
  localparam logic [9:0]  VOWEL_SPAN = 10'd28;

  localparam logic [4:0] INS_DIV  = 5'd2;
  localparam logic [4:0] INS_ADD  = 5'd3;
  localparam logic [4:0] INS_MUL  = 5'd4;
  localparam logic [4:0] INS_MOD  = 5'd5;
  localparam logic [4:0] INS_OUT  = 5'd6;
  localparam logic [4:0] INS_PUSH = 5'd7;
  localparam logic [4:0] INS_DUP  = 5'd8;
  localparam logic [4:0] INS_SEL  = 5'd9;
  localparam logic [4:0] INS_MOVE = 5'd10;
  localparam logic [4:0] INS_CMP  = 5'd12;
  localparam logic [4:0] INS_BR   = 5'd14;
  localparam logic [4:0] INS_SUB  = 5'd16;
  localparam logic [4:0] INS_SWAP = 5'd17;
  localparam logic [4:0] INS_EXIT = 5'd18;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_NUM  = 3'd1;
  localparam logic [2:0] EV_CHR  = 3'd2;
  localparam logic [2:0] EV_EXIT = 3'd3;
  localparam logic [2:0] EV_HALT = 3'd4;

  localparam logic [0:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_CMP,
    ALU_DIV,
    ALU_MOD
  } alu_op_e;

  function automatic logic [1:0] operands_needed(logic [4:0] ins);
    logic [1:0] n;
    unique case (ins)
      INS_DIV, INS_ADD, INS_MUL, INS_MOD, INS_CMP, INS_SUB, INS_SWAP: n = 2'd2;
      INS_OUT, INS_DUP, INS_MOVE, INS_BR:                             n = 2'd1;
      default:                                                        n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] stroke_count(logic [4:0] fin);
    logic [3:0] c;
    unique case (fin)
      5'd0:                                    c = 4'd0;
      5'd1, 5'd19:                             c = 4'd2;
      5'd2, 5'd3, 5'd16, 5'd17, 5'd20, 5'd23,
      5'd25, 5'd26:                            c = 4'd4;
      5'd4:                                    c = 4'd2;
      5'd5, 5'd6, 5'd8:                        c = 4'd5;
      5'd7, 5'd22, 5'd24, 5'd27:               c = 4'd3;
      5'd9, 5'd12:                             c = 4'd7;
      5'd10, 5'd11, 5'd13, 5'd14:              c = 4'd9;
      5'd15:                                   c = 4'd8;
      5'd18:                                   c = 4'd6;
      5'd21:                                   c = 4'd1;
      default:                                 c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- design/hgsm_alu.sv -----
module hgsm_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  hgsm_pkg::alu_op_e op_i,
  input  logic [31:0]       x_i,
  input  logic [31:0]       y_i,
  output logic              done_o,
  output logic [31:0]       res_o
);
  import hgsm_pkg::*;

  logic        run_q;
  logic [5:0]  cnt_q;
  logic [31:0] rem_q, quo_q, dy_q, res_q;
  logic        negq_q, negr_q, mod_q, done_q;
  logic [32:0] rsh;
  logic [32:0] rdiff;
  logic [63:0] prod;

  assign rsh   = {rem_q, quo_q[31]};
  assign rdiff = rsh - {1'b0, dy_q};
  assign prod  = x_i * y_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dy_q   <= '0;
      res_q  <= '0;
      negq_q <= 1'b0;
      negr_q <= 1'b0;
      mod_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        unique case (op_i)
          ALU_ADD: begin
            res_q  <= x_i + y_i;
            done_q <= 1'b1;
          end
          ALU_SUB: begin
            res_q  <= x_i - y_i;
            done_q <= 1'b1;
          end
          ALU_MUL: begin
            res_q  <= prod[31:0];
            done_q <= 1'b1;
          end
          ALU_CMP: begin
            res_q  <= ($signed(x_i) >= $signed(y_i)) ? 32'd1 : 32'd0;
            done_q <= 1'b1;
          end
          ALU_DIV, ALU_MOD: begin
            if (y_i == '0) begin
              res_q  <= '0;
              done_q <= 1'b1;
            end else begin
              quo_q  <= x_i[31] ? -x_i : x_i;
              dy_q   <= y_i[31] ? -y_i : y_i;
              rem_q  <= '0;
              cnt_q  <= 6'd32;
              negq_q <= x_i[31] ^ y_i[31];
              negr_q <= x_i[31];
              mod_q  <= (op_i == ALU_MOD);
              run_q  <= 1'b1;
            end
          end
          default: begin
            res_q  <= '0;
            done_q <= 1'b1;
          end
        endcase
      end else if (run_q) begin
        if (cnt_q != '0) begin
          if (!rdiff[32]) begin
            rem_q <= rdiff[31:0];
            quo_q <= {quo_q[30:0], 1'b1};
          end else begin
            rem_q <= rsh[31:0];
            quo_q <= {quo_q[30:0], 1'b0};
          end
          cnt_q <= cnt_q - 6'd1;
        end else begin
          if (mod_q) begin
            res_q <= negr_q ? -rem_q : rem_q;
          end else begin
            res_q <= negq_q ? -quo_q : quo_q;
          end
          done_q <= 1'b1;
          run_q  <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- design/hgsm_prog_mem.sv -----
module hgsm_prog_mem #(
  parameter int DEPTH = hgsm_pkg::GRID_COLS_DEF * hgsm_pkg::GRID_ROWS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [13:0]              wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [13:0]              rdata_o,
  output logic                     ready_o
);
  import hgsm_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [13:0]   mem [DEPTH];
  logic [13:0]   rdata_q;
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic          mwe;
  logic [AW-1:0] maddr;
  logic [13:0]   mdata;

  assign mwe   = clr_q | we_i;
  assign maddr = clr_q ? clr_cnt_q : waddr_i;
  assign mdata = clr_q ? NOP_CELL : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (clr_cnt_q == AW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      mem[maddr] <= mdata;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign ready_o = !clr_q;

endmodule

// ----- design/hangul_grid_stack_machine.sv -----
// Grid stack machine. start_i is taken when busy_o is low; each transaction
// gives exactly one result, shown on the result ports for one cycle with
// done_o high, and the receiver cannot stall it. An ordinary step runs cell
// fetch, decode (DEC1, DEC2, DEC3, DIR), two store reads, execute,
// arithmetic or store write, and cursor move. A step that finds too few
// values on its store goes from the fill check straight to the cursor move,
// and halted machines ignore steps. Divide and modulo run on the one bit per
// cycle divider in the shared arithmetic unit. After reset busy_o stays high
// while the program memory is cleared to no-ops; configuration writes are
// taken at all times.
`include "hangul_grid_stack_machine_defines.svh"

module hangul_grid_stack_machine #(
  parameter int GRID_COLS   = hgsm_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS   = hgsm_pkg::GRID_ROWS_DEF,
  parameter int STORE_DEPTH = hgsm_pkg::STORE_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               mode_i,
  input  logic [6:0]         cell_col_i,
  input  logic [6:0]         cell_row_i,
  input  logic [20:0]        code_point_i,
  input  logic signed [31:0] input_value_i,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_addr_i,
  input  logic [7:0]         cfg_wdata_i,
  output logic               done_o,
  output logic [2:0]         event_res_o,
  output logic signed [31:0] out_value_o,
  output logic               reversed_for_underflow_o,
  output logic               push_overflow_o,
  output logic               took_input_o
);
  import hgsm_pkg::*;

  localparam int CW     = $clog2(GRID_COLS);
  localparam int RW     = $clog2(GRID_ROWS);
  localparam int PDEPTH = GRID_COLS * GRID_ROWS;
  localparam int PAW    = $clog2(PDEPTH);
  localparam int QW     = $clog2(STORE_DEPTH);
  localparam int FW     = $clog2(STORE_DEPTH + 1);
  localparam int VDEPTH = NUM_STORES * STORE_DEPTH;
  localparam int VAW    = $clog2(VDEPTH);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_LOAD  = 5'd1;
  localparam logic [4:0] ST_HALT  = 5'd2;
  localparam logic [4:0] ST_FETCH = 5'd3;
  localparam logic [4:0] ST_DEC1  = 5'd4;
  localparam logic [4:0] ST_DEC2  = 5'd5;
  localparam logic [4:0] ST_DEC3  = 5'd6;
  localparam logic [4:0] ST_DIR   = 5'd7;
  localparam logic [4:0] ST_RD0   = 5'd8;
  localparam logic [4:0] ST_RD1   = 5'd9;
  localparam logic [4:0] ST_RD2   = 5'd10;
  localparam logic [4:0] ST_EXEC  = 5'd11;
  localparam logic [4:0] ST_WAIT  = 5'd12;
  localparam logic [4:0] ST_PUSH  = 5'd13;
  localparam logic [4:0] ST_PUSHF = 5'd14;
  localparam logic [4:0] ST_SWAP0 = 5'd15;
  localparam logic [4:0] ST_SWAP1 = 5'd16;
  localparam logic [4:0] ST_MOVE  = 5'd17;

  logic [4:0]  state_q;
  logic [7:0]  grid_width_q, grid_height_q;

  logic [PAW-1:0] ld_addr_q;
  logic [13:0]    ld_cell_q;
  logic           ld_ok_q;
  logic [31:0]    inval_q;

  logic [CW-1:0]   cur_col_q;
  logic [RW-1:0]   cur_row_q;
  logic signed [2:0] dir_col_q, dir_row_q;
  logic            halted_q;
  logic [4:0]      cur_store_q;
  logic [QW-1:0]   head_q;
  logic [FW-1:0]   fill_q [NUM_STORES];

  logic [13:0] cell_q;
  logic [4:0]  init_q, vowel_q, fin_q, tgt_q;
  logic [9:0]  r1_q;
  logic [1:0]  need_q;
  logic [31:0] a_q, b_q, push_val_q;

  logic [2:0]  ev_q;
  logic [31:0] val_q;
  logic        under_q, over_q, took_q;

  logic        done_q;
  logic [2:0]  res_ev_q;
  logic [31:0] res_val_q;
  logic        res_under_q, res_over_q, res_took_q;

  logic           pm_ready, pm_we;
  logic [PAW-1:0] pm_raddr;
  logic [13:0]    pm_rdata;

  logic              alu_start, alu_done;
  alu_op_e           alu_op;
  logic [31:0]       alu_res;

  logic [31:0]    vmem [VDEPTH];
  logic [31:0]    vrdata_q;
  logic           vwe;
  logic [VAW-1:0] vwaddr, vraddr;
  logic [31:0]    vwdata;

  logic [4:0]    fill_idx;
  logic [FW-1:0] fill_sel;
  logic          is_queue, tgt_queue, full;
  logic [QW-1:0] slot0, slot1, push_idx, head_dec, head_pop;
  logic [QW:0]   qsum1, hsum;
  logic [FW:0]   psum;
  logic [CW:0]   lim_w;
  logic [RW:0]   lim_h;
  logic [28:0]   dprod1;
  logic [19:0]   dprod2;
  logic signed [2:0] nd_col, nd_row;

  function automatic logic [VAW-1:0] vaddr(logic [4:0] st, logic [QW-1:0] idx);
    return VAW'(VAW'(st) * VAW'(STORE_DEPTH)) + VAW'(idx);
  endfunction

  function automatic logic [CW-1:0] wrap_col(logic [CW-1:0] pos, logic signed [2:0] d,
                                             logic [CW:0] lim);
    logic signed [CW+1:0] p;
    p = $signed({2'b00, pos}) + (CW+2)'(d);
    if (p < 0) p = $signed({1'b0, lim}) - (CW+2)'(1);
    if (p >= $signed({1'b0, lim})) p = '0;
    return p[CW-1:0];
  endfunction

  function automatic logic [RW-1:0] wrap_row(logic [RW-1:0] pos, logic signed [2:0] d,
                                             logic [RW:0] lim);
    logic signed [RW+1:0] p;
    p = $signed({2'b00, pos}) + (RW+2)'(d);
    if (p < 0) p = $signed({1'b0, lim}) - (RW+2)'(1);
    if (p >= $signed({1'b0, lim})) p = '0;
    return p[RW-1:0];
  endfunction

  hgsm_prog_mem #(
    .DEPTH(PDEPTH)
  ) u_prog_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pm_we),
    .waddr_i (ld_addr_q),
    .wdata_i (ld_cell_q),
    .raddr_i (pm_raddr),
    .rdata_o (pm_rdata),
    .ready_o (pm_ready)
  );

  hgsm_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .op_i    (alu_op),
    .x_i     (b_q),
    .y_i     (a_q),
    .done_o  (alu_done),
    .res_o   (alu_res)
  );

  assign busy_o   = (state_q != ST_IDLE) || !pm_ready;
  assign pm_we    = (state_q == ST_LOAD) && ld_ok_q;
  assign pm_raddr = PAW'(PAW'(cur_row_q) * PAW'(GRID_COLS)) + PAW'(cur_col_q);

  assign lim_w = (grid_width_q == '0) ? (CW+1)'(1) :
                 (int'(grid_width_q) > GRID_COLS) ? (CW+1)'(GRID_COLS) :
                 (CW+1)'(grid_width_q);
  assign lim_h = (grid_height_q == '0) ? (RW+1)'(1) :
                 (int'(grid_height_q) > GRID_ROWS) ? (RW+1)'(GRID_ROWS) :
                 (RW+1)'(grid_height_q);

  assign dprod1 = 29'(cell_q) * 29'(DEC_M1);
  assign dprod2 = 20'(r1_q) * 20'(DEC_M2);

  assign fill_idx  = (state_q == ST_PUSH) ? tgt_q : cur_store_q;
  assign fill_sel  = fill_q[fill_idx];
  assign full      = (fill_sel >= FW'(STORE_DEPTH));
  assign is_queue  = (cur_store_q == QUEUE_STORE);
  assign tgt_queue = (tgt_q == QUEUE_STORE);

  assign qsum1 = (QW+1)'(head_q) + (QW+1)'(1);
  assign slot0 = is_queue ? head_q : QW'(fill_sel - FW'(1));
  assign slot1 = is_queue ? ((qsum1 >= (QW+1)'(STORE_DEPTH)) ?
                             QW'(qsum1 - (QW+1)'(STORE_DEPTH)) : QW'(qsum1)) :
                            QW'(fill_sel - FW'(2));

  assign psum     = (FW+1)'(head_q) + (FW+1)'(fill_sel);
  assign push_idx = tgt_queue ? ((psum >= (FW+1)'(STORE_DEPTH)) ?
                                 QW'(psum - (FW+1)'(STORE_DEPTH)) : QW'(psum)) :
                                QW'(fill_sel);
  assign head_dec = (head_q == '0) ? QW'(STORE_DEPTH - 1) : head_q - QW'(1);
  assign hsum     = (QW+1)'(head_q) + (QW+1)'(need_q);
  assign head_pop = (hsum >= (QW+1)'(STORE_DEPTH)) ?
                    QW'(hsum - (QW+1)'(STORE_DEPTH)) : QW'(hsum);

  always_comb begin
    nd_col = dir_col_q;
    nd_row = dir_row_q;
    unique case (vowel_q)
      5'd0:  begin nd_col = 3'sd1;  nd_row = 3'sd0;  end
      5'd2:  begin nd_col = 3'sd2;  nd_row = 3'sd0;  end
      5'd4:  begin nd_col = -3'sd1; nd_row = 3'sd0;  end
      5'd6:  begin nd_col = -3'sd2; nd_row = 3'sd0;  end
      5'd8:  begin nd_col = 3'sd0;  nd_row = -3'sd1; end
      5'd12: begin nd_col = 3'sd0;  nd_row = -3'sd2; end
      5'd13: begin nd_col = 3'sd0;  nd_row = 3'sd1;  end
      5'd17: begin nd_col = 3'sd0;  nd_row = 3'sd2;  end
      5'd18: nd_row = -dir_row_q;
      5'd19: begin nd_col = -dir_col_q; nd_row = -dir_row_q; end
      5'd20: nd_col = -dir_col_q;
      default: ;
    endcase
  end

  always_comb begin
    alu_start = (state_q == ST_EXEC) &&
                (init_q == INS_DIV || init_q == INS_MOD || init_q == INS_ADD ||
                 init_q == INS_MUL || init_q == INS_SUB || init_q == INS_CMP);
    unique case (init_q)
      INS_DIV: alu_op = ALU_DIV;
      INS_MOD: alu_op = ALU_MOD;
      INS_MUL: alu_op = ALU_MUL;
      INS_SUB: alu_op = ALU_SUB;
      INS_CMP: alu_op = ALU_CMP;
      default: alu_op = ALU_ADD;
    endcase
  end

  always_comb begin
    vwe    = 1'b0;
    vwaddr = vaddr(cur_store_q, slot0);
    vwdata = a_q;
    unique case (state_q)
      ST_PUSH: begin
        vwe    = !full;
        vwaddr = vaddr(tgt_q, push_idx);
        vwdata = push_val_q;
      end
      ST_PUSHF: begin
        vwe    = !full;
        vwaddr = vaddr(QUEUE_STORE, head_dec);
      end
      ST_SWAP0: begin
        vwe    = 1'b1;
        vwdata = b_q;
      end
      ST_SWAP1: begin
        vwe    = 1'b1;
        vwaddr = vaddr(cur_store_q, slot1);
      end
      default: ;
    endcase
  end

  assign vraddr = (state_q == ST_RD1) ? vaddr(cur_store_q, slot1) : vaddr(cur_store_q, slot0);

  always_ff @(posedge clk_i) begin
    if (vwe) begin
      vmem[vwaddr] <= vwdata;
    end
    vrdata_q <= vmem[vraddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= 8'd1;
      grid_height_q <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i;
        CFG_GRID_HEIGHT: grid_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ld_addr_q   <= '0;
      ld_cell_q   <= '0;
      ld_ok_q     <= 1'b0;
      inval_q     <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      dir_col_q   <= 3'sd0;
      dir_row_q   <= 3'sd1;
      halted_q    <= 1'b0;
      cur_store_q <= '0;
      head_q      <= '0;
      for (int i = 0; i < NUM_STORES; i++) fill_q[i] <= '0;
      cell_q      <= '0;
      init_q      <= '0;
      vowel_q     <= '0;
      fin_q       <= '0;
      tgt_q       <= '0;
      r1_q        <= '0;
      need_q      <= '0;
      a_q         <= '0;
      b_q         <= '0;
      push_val_q  <= '0;
      ev_q        <= EV_NONE;
      val_q       <= '0;
      under_q     <= 1'b0;
      over_q      <= 1'b0;
      took_q      <= 1'b0;
      done_q      <= 1'b0;
      res_ev_q    <= EV_NONE;
      res_val_q   <= '0;
      res_under_q <= 1'b0;
      res_over_q  <= 1'b0;
      res_took_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i && !busy_o) begin
            ev_q    <= EV_NONE;
            val_q   <= '0;
            under_q <= 1'b0;
            over_q  <= 1'b0;
            took_q  <= 1'b0;
            inval_q <= input_value_i;
            ld_ok_q <= (int'(cell_col_i) < GRID_COLS) && (int'(cell_row_i) < GRID_ROWS);
            ld_addr_q <= PAW'(PAW'(cell_row_i) * PAW'(GRID_COLS)) + PAW'(cell_col_i);
            ld_cell_q <= (code_point_i >= HANGUL_FIRST && code_point_i <= HANGUL_LAST) ?
                         14'(code_point_i - HANGUL_FIRST) : NOP_CELL;
            if (!mode_i) begin
              state_q <= ST_LOAD;
            end else if (halted_q) begin
              state_q <= ST_HALT;
            end else begin
              state_q <= ST_FETCH;
            end
          end
        end
        ST_LOAD: begin
          done_q      <= 1'b1;
          res_ev_q    <= EV_NONE;
          res_val_q   <= '0;
          res_under_q <= 1'b0;
          res_over_q  <= 1'b0;
          res_took_q  <= 1'b0;
          state_q     <= ST_IDLE;
        end
        ST_HALT: begin
          done_q      <= 1'b1;
          res_ev_q    <= EV_HALT;
          res_val_q   <= '0;
          res_under_q <= 1'b0;
          res_over_q  <= 1'b0;
          res_took_q  <= 1'b0;
          state_q     <= ST_IDLE;
        end
        ST_FETCH: state_q <= ST_DEC1;
        ST_DEC1: begin
          cell_q  <= pm_rdata;
          state_q <= ST_DEC2;
        end
        ST_DEC2: begin
          init_q  <= dprod1[28:24];
          state_q <= ST_DEC3;
        end
        ST_DEC3: begin
          r1_q    <= 10'(cell_q - 14'(14'(init_q) * 14'(INIT_SPAN)));
          state_q <= ST_DIR;
        end
        ST_DIR: begin
          vowel_q <= dprod2[18:14];
          state_q <= ST_RD0;
        end
        ST_RD0: begin
          fin_q  <= 5'(r1_q - 10'(10'(vowel_q) * VOWEL_SPAN));
          need_q <= operands_needed(init_q);
          if (fill_sel < FW'(operands_needed(init_q))) begin
            under_q   <= 1'b1;
            dir_col_q <= -nd_col;
            dir_row_q <= -nd_row;
            state_q   <= ST_MOVE;
          end else begin
            dir_col_q <= nd_col;
            dir_row_q <= nd_row;
            state_q   <= ST_RD1;
          end
        end
        ST_RD1: begin
          a_q     <= vrdata_q;
          state_q <= ST_RD2;
        end
        ST_RD2: begin
          b_q     <= vrdata_q;
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (need_q != '0 && init_q != INS_DUP && init_q != INS_SWAP) begin
            fill_q[cur_store_q] <= fill_sel - FW'(need_q);
            if (is_queue) head_q <= head_pop;
          end
          tgt_q <= (init_q == INS_MOVE) ? fin_q : cur_store_q;
          priority case (init_q)
            INS_DIV, INS_MOD, INS_ADD, INS_MUL, INS_SUB, INS_CMP: state_q <= ST_WAIT;
            INS_OUT: begin
              if (fin_q == FIN_IN_NUM) begin
                ev_q  <= EV_NUM;
                val_q <= a_q;
              end else if (fin_q == FIN_IN_CHR) begin
                ev_q  <= EV_CHR;
                val_q <= a_q;
              end
              state_q <= ST_MOVE;
            end
            INS_PUSH: begin
              if (fin_q == FIN_IN_NUM || fin_q == FIN_IN_CHR) begin
                took_q     <= 1'b1;
                push_val_q <= inval_q;
              end else begin
                push_val_q <= 32'(stroke_count(fin_q));
              end
              state_q <= ST_PUSH;
            end
            INS_DUP: begin
              push_val_q <= a_q;
              state_q    <= is_queue ? ST_PUSHF : ST_PUSH;
            end
            INS_SEL: begin
              cur_store_q <= fin_q;
              state_q     <= ST_MOVE;
            end
            INS_MOVE: begin
              push_val_q <= a_q;
              state_q    <= ST_PUSH;
            end
            INS_BR: begin
              if (a_q == '0) begin
                dir_col_q <= -dir_col_q;
                dir_row_q <= -dir_row_q;
              end
              state_q <= ST_MOVE;
            end
            INS_SWAP: state_q <= ST_SWAP0;
            INS_EXIT: begin
              halted_q    <= 1'b1;
              done_q      <= 1'b1;
              res_ev_q    <= EV_EXIT;
              res_val_q   <= (fill_sel != '0) ? a_q : '0;
              res_under_q <= 1'b0;
              res_over_q  <= 1'b0;
              res_took_q  <= 1'b0;
              state_q     <= ST_IDLE;
            end
            default: state_q <= ST_MOVE;
          endcase
        end
        ST_WAIT: begin
          if (alu_done) begin
            push_val_q <= alu_res;
            state_q    <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (full) begin
            over_q <= 1'b1;
          end else begin
            fill_q[tgt_q] <= fill_sel + FW'(1);
          end
          state_q <= ST_MOVE;
        end
        ST_PUSHF: begin
          if (full) begin
            over_q <= 1'b1;
          end else begin
            head_q              <= head_dec;
            fill_q[cur_store_q] <= fill_sel + FW'(1);
          end
          state_q <= ST_MOVE;
        end
        ST_SWAP0: state_q <= ST_SWAP1;
        ST_SWAP1: state_q <= ST_MOVE;
        ST_MOVE: begin
          cur_row_q   <= wrap_row(cur_row_q, dir_row_q, lim_h);
          cur_col_q   <= wrap_col(cur_col_q, dir_col_q, lim_w);
          done_q      <= 1'b1;
          res_ev_q    <= ev_q;
          res_val_q   <= val_q;
          res_under_q <= under_q;
          res_over_q  <= over_q;
          res_took_q  <= took_q;
          state_q     <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o                   = done_q;
  assign event_res_o              = res_ev_q;
  assign out_value_o              = res_val_q;
  assign reversed_for_underflow_o = res_under_q;
  assign push_overflow_o          = res_over_q;
  assign took_input_o             = res_took_q;

  `HGSM_ASSERT(a_done_in_idle, done_o |-> (state_q == ST_IDLE), "result outside idle")
  `HGSM_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "accepted item not busy")
  `HGSM_ASSERT(a_halt_sticky, halted_q |=> halted_q, "halted flag cleared")
  `HGSM_ASSERT(a_fill_bound, fill_sel <= FW'(STORE_DEPTH), "store fill beyond depth")
  `HGSM_ASSERT_ALWAYS(a_no_done_reset, !rst_ni |-> !done_o, "result during reset")

endmodule
